@@ sv/instruction_fetch_request_fsm_core_defines.svh @@
// Assertion macros shared by the fetch request block.
`ifndef INSTRUCTION_FETCH_REQUEST_FSM_CORE_DEFINES_SVH
`define INSTRUCTION_FETCH_REQUEST_FSM_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define IFR_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("fetch request block: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define IFR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("fetch request block: next-cycle check failed");

`endif

@@ sv/ifr_pkg.sv @@
package ifr_pkg;

	// Port field width fixed by the interface
	localparam int FIELD_BITS = 32;

	typedef logic [FIELD_BITS-1:0] field_t;

	// One input word: one clock tick of the fetch stage
	typedef struct packed {
		logic   predict_valid;
		field_t predict_address;
		logic   mem_accept;
		logic   resp_valid;
		field_t resp_address;
		field_t resp_word;
		logic   resp_fault;
		logic   resp_exec_ok;
		logic   flush;
		logic   buffer_mode;
		field_t buffer_address;
		field_t buffer_word;
	} item_t;

	// One result word: registered state before the update
	typedef struct packed {
		logic   mem_request_valid;
		field_t mem_request_address;
		logic   mem_response_ready;
		field_t in_flight_address;
		field_t out_address;
		field_t out_word;
		logic   out_fault;
		logic   out_exec_ok;
	} result_t;

	// Occupancy of the result buffer
	typedef struct packed {
		logic out_full;
		logic skid_full;
	} buf_status_t;

endpackage

@@ sv/ifr_fsm.sv @@
module ifr_fsm #(
	parameter int ADDR_BITS = 32,
	parameter int WORD_BITS = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             advance,
	input  ifr_pkg::item_t   item,
	output ifr_pkg::result_t res
);

	typedef enum logic [1:0] {
		PH_IDLE        = 2'd0,
		PH_WAIT_ACCEPT = 2'd1,
		PH_WAIT_RESP   = 2'd2
	} phase_t;

	phase_t                 phase_q, phase_d;
	logic                   pend_q, pend_d;
	logic                   rdy_q, rdy_d;
	logic [ADDR_BITS-1:0]   fetch_addr_q, fetch_addr_d;
	logic [ADDR_BITS-1:0]   acc_addr_q, acc_addr_d;
	logic [ADDR_BITS-1:0]   cur_addr_q, cur_addr_d;
	logic [WORD_BITS-1:0]   cur_word_q, cur_word_d;
	logic                   cur_fault_q, cur_fault_d;
	logic                   cur_exec_q, cur_exec_d;

	logic [ADDR_BITS-1:0]   pa, ra, ba;
	logic [WORD_BITS-1:0]   rw, bw;
	logic                   next_req;

	// Bring port fields to internal widths
	assign pa       = ADDR_BITS'(item.predict_address);
	assign ra       = ADDR_BITS'(item.resp_address);
	assign ba       = ADDR_BITS'(item.buffer_address);
	assign rw       = WORD_BITS'(item.resp_word);
	assign bw       = WORD_BITS'(item.buffer_word);
	assign next_req = item.predict_valid & ~item.buffer_mode;

	// Present the state as it stands before this word's update
	assign res.mem_request_valid   = pend_q;
	assign res.mem_request_address = ifr_pkg::field_t'(fetch_addr_q);
	assign res.mem_response_ready  = rdy_q;
	assign res.in_flight_address   = ifr_pkg::field_t'(acc_addr_q);
	assign res.out_address         = ifr_pkg::field_t'(cur_addr_q);
	assign res.out_word            = ifr_pkg::field_t'(cur_word_q);
	assign res.out_fault           = cur_fault_q;
	assign res.out_exec_ok         = cur_exec_q;

	// Compute the next phase and captured values
	always_comb begin
		phase_d      = phase_q;
		pend_d       = pend_q;
		rdy_d        = rdy_q;
		fetch_addr_d = fetch_addr_q;
		acc_addr_d   = acc_addr_q;
		cur_addr_d   = cur_addr_q;
		cur_word_d   = cur_word_q;
		cur_fault_d  = cur_fault_q;
		cur_exec_d   = cur_exec_q;

		case (phase_q)
			PH_IDLE: begin
				pend_d = 1'b0;
				rdy_d  = 1'b0;
				if (item.buffer_mode) begin
					cur_addr_d  = ba;
					cur_word_d  = bw;
					cur_fault_d = 1'b0;
					cur_exec_d  = 1'b0;
				end else if (item.predict_valid) begin
					phase_d      = PH_WAIT_ACCEPT;
					fetch_addr_d = pa;
					pend_d       = 1'b1;
				end
			end
			PH_WAIT_ACCEPT: begin
				if (item.mem_accept) begin
					pend_d       = next_req;
					fetch_addr_d = pa;
					acc_addr_d   = fetch_addr_q;
					rdy_d        = 1'b1;
					phase_d      = PH_WAIT_RESP;
				end else if (item.predict_valid) begin
					fetch_addr_d = pa;
				end
			end
			PH_WAIT_RESP: begin
				if (item.resp_valid) begin
					cur_addr_d  = ra;
					cur_word_d  = rw;
					cur_fault_d = item.resp_fault;
					cur_exec_d  = item.resp_exec_ok;
					pend_d      = next_req;
					if (pend_q) begin
						if (item.mem_accept) begin
							fetch_addr_d = pa;
							acc_addr_d   = fetch_addr_q;
						end else begin
							phase_d = PH_WAIT_ACCEPT;
						end
					end else if (next_req) begin
						fetch_addr_d = pa;
						phase_d      = PH_WAIT_ACCEPT;
					end else begin
						// nothing more to fetch: park the request address
						fetch_addr_d = '1;
						phase_d      = PH_IDLE;
					end
				end
			end
			default: begin
				// unused phase code: hold everything
				phase_d = phase_q;
			end
		endcase

		// Flush overrides the stage output after the phase logic
		if (item.flush) begin
			pend_d      = 1'b0;
			cur_addr_d  = '1;
			cur_word_d  = '0;
			cur_fault_d = 1'b0;
			cur_exec_d  = 1'b0;
		end
	end

	// Hold state; advance once per accepted word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_IDLE;
			pend_q       <= 1'b0;
			rdy_q        <= 1'b0;
			fetch_addr_q <= '0;
			acc_addr_q   <= '0;
			cur_addr_q   <= '0;
			cur_word_q   <= '0;
			cur_fault_q  <= 1'b0;
			cur_exec_q   <= 1'b0;
		end else if (advance) begin
			phase_q      <= phase_d;
			pend_q       <= pend_d;
			rdy_q        <= rdy_d;
			fetch_addr_q <= fetch_addr_d;
			acc_addr_q   <= acc_addr_d;
			cur_addr_q   <= cur_addr_d;
			cur_word_q   <= cur_word_d;
			cur_fault_q  <= cur_fault_d;
			cur_exec_q   <= cur_exec_d;
		end
	end

endmodule

@@ sv/ifr_obuf.sv @@
module ifr_obuf (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  ifr_pkg::result_t     push_data,
	input  logic                 pop,
	output ifr_pkg::result_t     out_data,
	output ifr_pkg::buf_status_t status
);

	ifr_pkg::result_t out_q;
	ifr_pkg::result_t skid_q;
	logic             out_valid_q;
	logic             skid_valid_q;

	assign out_data         = out_q;
	assign status.out_full  = out_valid_q;
	assign status.skid_full = skid_valid_q;

	// Track occupancy; a push never meets a full buffer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (pop) begin
			if (skid_valid_q) begin
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= push;
			end
		end else if (push) begin
			if (out_valid_q) begin
				skid_valid_q <= 1'b1;
			end else begin
				out_valid_q <= 1'b1;
			end
		end
	end

	// Move payload: drain skid first, else load output directly
	always_ff @(posedge clk) begin
		if (pop) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
			end else if (push) begin
				out_q <= push_data;
			end
		end else if (push) begin
			if (out_valid_q) begin
				skid_q <= push_data;
			end else begin
				out_q <= push_data;
			end
		end
	end

endmodule

@@ sv/instruction_fetch_request_fsm_core.sv @@
// Each accepted input word pushes its result word into the result buffer.
// Throughput: one word per cycle unless item_stall is high; the fetch state
// register advances per accepted word, and a two-entry result buffer keeps
// input accepted under output stall; input stalls only when both are full.
// Reset (arst_n low, asynchronous): phase idle, all state and buffer cleared.
`include "instruction_fetch_request_fsm_core_defines.svh"

module instruction_fetch_request_fsm_core #(
	parameter int ADDR_BITS = 32,
	parameter int WORD_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        item_valid,
	output logic        item_stall,
	input  logic        predict_valid,
	input  logic [31:0] predict_address,
	input  logic        mem_accept,
	input  logic        resp_valid,
	input  logic [31:0] resp_address,
	input  logic [31:0] resp_word,
	input  logic        resp_fault,
	input  logic        resp_exec_ok,
	input  logic        flush,
	input  logic        buffer_mode,
	input  logic [31:0] buffer_address,
	input  logic [31:0] buffer_word,

	output logic        result_valid,
	input  logic        result_stall,
	output logic        mem_request_valid,
	output logic [31:0] mem_request_address,
	output logic        mem_response_ready,
	output logic [31:0] in_flight_address,
	output logic [31:0] out_address,
	output logic [31:0] out_word,
	output logic        out_fault,
	output logic        out_exec_ok
);

	ifr_pkg::item_t       item;
	ifr_pkg::result_t     cur_res;
	ifr_pkg::result_t     buf_res;
	ifr_pkg::buf_status_t buf_st;
	logic                 accept;
	logic                 pop;

	// Gather the input word
	assign item.predict_valid   = predict_valid;
	assign item.predict_address = predict_address;
	assign item.mem_accept      = mem_accept;
	assign item.resp_valid      = resp_valid;
	assign item.resp_address    = resp_address;
	assign item.resp_word       = resp_word;
	assign item.resp_fault      = resp_fault;
	assign item.resp_exec_ok    = resp_exec_ok;
	assign item.flush           = flush;
	assign item.buffer_mode     = buffer_mode;
	assign item.buffer_address  = buffer_address;
	assign item.buffer_word     = buffer_word;

	// Handshakes
	assign item_stall   = buf_st.skid_full;
	assign accept       = item_valid & ~item_stall;
	assign result_valid = buf_st.out_full;
	assign pop          = result_valid & ~result_stall;

	ifr_fsm #(
		.ADDR_BITS(ADDR_BITS),
		.WORD_BITS(WORD_BITS)
	) u_fsm (
		.clk    (clk),
		.arst_n (arst_n),
		.advance(accept),
		.item   (item),
		.res    (cur_res)
	);

	ifr_obuf u_obuf (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (accept),
		.push_data(cur_res),
		.pop      (pop),
		.out_data (buf_res),
		.status   (buf_st)
	);

	// Drive the result word
	assign mem_request_valid   = buf_res.mem_request_valid;
	assign mem_request_address = buf_res.mem_request_address;
	assign mem_response_ready  = buf_res.mem_response_ready;
	assign in_flight_address   = buf_res.in_flight_address;
	assign out_address         = buf_res.out_address;
	assign out_word            = buf_res.out_word;
	assign out_fault           = buf_res.out_fault;
	assign out_exec_ok         = buf_res.out_exec_ok;

	// Skid entry is only ever used behind a full output entry
	`IFR_ASSERT_SAME(a_skid_behind_out, clk, arst_n, buf_st.skid_full, buf_st.out_full)
	// A word accepted into an empty buffer shows up next cycle
	`IFR_ASSERT_NEXT(a_accept_shows, clk, arst_n, accept && !result_valid, result_valid)
	// A stalled result is never dropped
	`IFR_ASSERT_NEXT(a_stall_keeps, clk, arst_n, result_valid && result_stall, result_valid)

endmodule

@@ bench/fetch_tick_checker.sv @@
module fetch_tick_checker (
	input  logic            clk,
	input  logic            arst_n,

	input  logic            item_valid,
	input  logic            item_stall,
	input  logic            predict_valid,
	input  ifr_pkg::field_t predict_address,
	input  logic            mem_accept,
	input  logic            resp_valid,
	input  ifr_pkg::field_t resp_address,
	input  ifr_pkg::field_t resp_word,
	input  logic            resp_fault,
	input  logic            resp_exec_ok,
	input  logic            flush,
	input  logic            buffer_mode,
	input  ifr_pkg::field_t buffer_address,
	input  ifr_pkg::field_t buffer_word,

	input  logic            result_valid,
	input  logic            result_stall,
	input  logic            mem_request_valid,
	input  ifr_pkg::field_t mem_request_address,
	input  logic            mem_response_ready,
	input  ifr_pkg::field_t in_flight_address,
	input  ifr_pkg::field_t out_address,
	input  ifr_pkg::field_t out_word,
	input  logic            out_fault,
	input  logic            out_exec_ok,

	output int              fail_count,
	output int              expected_left,
	output int              words_checked
);

	typedef enum logic [1:0] {
		FETCH_IDLE,
		FETCH_WAIT_ACCEPT,
		FETCH_WAIT_RESP
	} fetch_phase_t;

	localparam int PRINT_LIMIT = 20;

	// Shadow copy of the fetch state
	fetch_phase_t    fetch_phase;
	logic            req_pending;
	logic            rsp_rdy;
	ifr_pkg::field_t fetch_addr;
	ifr_pkg::field_t accepted_addr;
	ifr_pkg::field_t cur_addr;
	ifr_pkg::field_t cur_word;
	logic            cur_fault;
	logic            cur_exec_ok;

	ifr_pkg::result_t expected_ticks_q[$];

	task automatic report_mismatch(input string what, input ifr_pkg::field_t got,
		input ifr_pkg::field_t want);
		fail_count++;
		if (fail_count <= PRINT_LIMIT) begin
			$display("mismatch on %s: got %h, want %h", what, got, want);
		end
	endtask

	// Produce the result word for one tick and advance the shadow state
	task automatic predict_fetch(input ifr_pkg::item_t t, output ifr_pkg::result_t r);
		fetch_phase_t    n_phase;
		logic            n_pend;
		logic            n_rdy;
		logic            n_fault;
		logic            n_exec;
		logic            next_req;
		ifr_pkg::field_t n_req;
		ifr_pkg::field_t n_acc;
		ifr_pkg::field_t n_cur;
		ifr_pkg::field_t n_word;

		n_phase  = fetch_phase;
		n_pend   = req_pending;
		n_rdy    = rsp_rdy;
		n_req    = fetch_addr;
		n_acc    = accepted_addr;
		n_cur    = cur_addr;
		n_word   = cur_word;
		n_fault  = cur_fault;
		n_exec   = cur_exec_ok;
		next_req = t.predict_valid && !t.buffer_mode;

		// Outputs show the registers before the edge
		r = {req_pending, fetch_addr, rsp_rdy, accepted_addr,
			cur_addr, cur_word, cur_fault, cur_exec_ok};

		case (fetch_phase)
			FETCH_IDLE: begin
				n_pend = 1'b0;
				n_rdy  = 1'b0;
				if (t.buffer_mode) begin
					n_cur   = t.buffer_address;
					n_word  = t.buffer_word;
					n_fault = 1'b0;
					n_exec  = 1'b0;
				end else if (t.predict_valid) begin
					n_phase = FETCH_WAIT_ACCEPT;
					n_req   = t.predict_address;
					n_pend  = 1'b1;
				end
			end
			FETCH_WAIT_ACCEPT: begin
				if (t.mem_accept) begin
					n_pend  = next_req;
					n_req   = t.predict_address;
					n_acc   = fetch_addr;
					n_rdy   = 1'b1;
					n_phase = FETCH_WAIT_RESP;
				end else if (t.predict_valid) begin
					n_req = t.predict_address;
				end
			end
			FETCH_WAIT_RESP: begin
				if (t.resp_valid) begin
					n_cur   = t.resp_address;
					n_word  = t.resp_word;
					n_fault = t.resp_fault;
					n_exec  = t.resp_exec_ok;
					n_pend  = next_req;
					if (req_pending) begin
						if (t.mem_accept) begin
							n_req = t.predict_address;
							n_acc = fetch_addr;
						end else begin
							n_phase = FETCH_WAIT_ACCEPT;
						end
					end else if (next_req) begin
						n_req   = t.predict_address;
						n_phase = FETCH_WAIT_ACCEPT;
					end else begin
						// nothing further to fetch: park the address and go idle
						n_req   = '1;
						n_phase = FETCH_IDLE;
					end
				end
			end
			default: begin
			end
		endcase

		// Flush wins over the phase logic for the output registers
		if (t.flush) begin
			n_pend  = 1'b0;
			n_cur   = '1;
			n_word  = '0;
			n_fault = 1'b0;
			n_exec  = 1'b0;
		end

		fetch_phase   = n_phase;
		req_pending   = n_pend;
		rsp_rdy       = n_rdy;
		fetch_addr    = n_req;
		accepted_addr = n_acc;
		cur_addr      = n_cur;
		cur_word      = n_word;
		cur_fault     = n_fault;
		cur_exec_ok   = n_exec;
	endtask

	// Compare each result word with the oldest expectation, then queue the new one
	always @(posedge clk or negedge arst_n) begin : watch
		ifr_pkg::result_t got;
		ifr_pkg::result_t want;
		ifr_pkg::item_t   tick;

		if (!arst_n) begin
			fetch_phase   = FETCH_IDLE;
			req_pending   = 1'b0;
			rsp_rdy       = 1'b0;
			fetch_addr    = '0;
			accepted_addr = '0;
			cur_addr      = '0;
			cur_word      = '0;
			cur_fault     = 1'b0;
			cur_exec_ok   = 1'b0;
			expected_ticks_q.delete();
			fail_count    = 0;
			expected_left = 0;
			words_checked = 0;
		end else begin
			if (result_valid && !result_stall) begin
				got = {mem_request_valid, mem_request_address, mem_response_ready,
					in_flight_address, out_address, out_word, out_fault, out_exec_ok};
				if (expected_ticks_q.size() == 0) begin
					report_mismatch("result word with nothing expected", '0, '0);
				end else begin
					want = expected_ticks_q.pop_front();
					words_checked++;
					if (got.mem_request_valid !== want.mem_request_valid)
						report_mismatch("mem_request_valid",
							ifr_pkg::field_t'(got.mem_request_valid),
							ifr_pkg::field_t'(want.mem_request_valid));
					if (got.mem_request_address !== want.mem_request_address)
						report_mismatch("mem_request_address", got.mem_request_address,
							want.mem_request_address);
					if (got.mem_response_ready !== want.mem_response_ready)
						report_mismatch("mem_response_ready",
							ifr_pkg::field_t'(got.mem_response_ready),
							ifr_pkg::field_t'(want.mem_response_ready));
					if (got.in_flight_address !== want.in_flight_address)
						report_mismatch("in_flight_address", got.in_flight_address,
							want.in_flight_address);
					if (got.out_address !== want.out_address)
						report_mismatch("out_address", got.out_address, want.out_address);
					if (got.out_word !== want.out_word)
						report_mismatch("out_word", got.out_word, want.out_word);
					if (got.out_fault !== want.out_fault)
						report_mismatch("out_fault", ifr_pkg::field_t'(got.out_fault),
							ifr_pkg::field_t'(want.out_fault));
					if (got.out_exec_ok !== want.out_exec_ok)
						report_mismatch("out_exec_ok", ifr_pkg::field_t'(got.out_exec_ok),
							ifr_pkg::field_t'(want.out_exec_ok));
				end
			end
			if (item_valid && !item_stall) begin
				tick = {predict_valid, predict_address, mem_accept, resp_valid, resp_address,
					resp_word, resp_fault, resp_exec_ok, flush, buffer_mode,
					buffer_address, buffer_word};
				predict_fetch(tick, want);
				expected_ticks_q.push_back(want);
			end
			expected_left = expected_ticks_q.size();
		end
	end

endmodule

@@ bench/instruction_fetch_request_fsm_core_tb.sv @@
module instruction_fetch_request_fsm_core_tb;

	localparam int RANDOM_TICKS   = 1250;
	localparam int HOLD_OFF_START = 400;
	localparam int HOLD_OFF_BURST = 40;
	localparam int HOLD_OFF_LEN   = 80;
	localparam int DRAIN_AT       = 800;
	localparam int WATCHDOG_LIMIT = 2000;

	logic            clk;
	logic            arst_n;
	logic            item_valid;
	logic            item_stall;
	logic            predict_valid;
	ifr_pkg::field_t predict_address;
	logic            mem_accept;
	logic            resp_valid;
	ifr_pkg::field_t resp_address;
	ifr_pkg::field_t resp_word;
	logic            resp_fault;
	logic            resp_exec_ok;
	logic            flush;
	logic            buffer_mode;
	ifr_pkg::field_t buffer_address;
	ifr_pkg::field_t buffer_word;
	logic            result_valid;
	logic            result_stall;
	logic            mem_request_valid;
	ifr_pkg::field_t mem_request_address;
	logic            mem_response_ready;
	ifr_pkg::field_t in_flight_address;
	ifr_pkg::field_t out_address;
	ifr_pkg::field_t out_word;
	logic            out_fault;
	logic            out_exec_ok;

	int fail_count;
	int expected_left;
	int words_checked;

	int hold_requests = 0;
	int ticks_sent    = 0;
	int flush_ticks   = 0;
	int buffer_ticks  = 0;

	instruction_fetch_request_fsm_core uut (.*);

	fetch_tick_checker chk (.*);

	// Free-running clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic ifr_pkg::field_t pick_addr();
		int r;
		r = $urandom_range(0, 99);
		if (r < 10)
			return '0;
		else if (r < 20)
			return '1;
		else if (r < 30)
			return ifr_pkg::field_t'($urandom_range(0, 255));
		return $urandom();
	endfunction

	function automatic int pick_gap(input int idx);
		int r;
		r = $urandom_range(0, 99);
		// keep some stretches back to back
		if (idx % 300 < 50)
			return 0;
		if (r < 70)
			return 0;
		else if (r < 95)
			return $urandom_range(1, 3);
		return $urandom_range(8, 25);
	endfunction

	function automatic ifr_pkg::item_t make_tick(
		input logic pv, input ifr_pkg::field_t pa, input logic acc, input logic rv,
		input ifr_pkg::field_t ra, input ifr_pkg::field_t rw, input logic rf,
		input logic rx, input logic fl, input logic bm, input ifr_pkg::field_t ba,
		input ifr_pkg::field_t bw);
		return {pv, pa, acc, rv, ra, rw, rf, rx, fl, bm, ba, bw};
	endfunction

	function automatic ifr_pkg::item_t random_tick(input int flush_pct, input int buffer_pct);
		ifr_pkg::item_t t;
		t.predict_valid   = $urandom_range(0, 99) < 65;
		t.predict_address = pick_addr();
		t.mem_accept      = $urandom_range(0, 99) < 50;
		t.resp_valid      = $urandom_range(0, 99) < 45;
		t.resp_address    = pick_addr();
		t.resp_word       = $urandom();
		t.resp_fault      = $urandom_range(0, 1) == 1;
		t.resp_exec_ok    = $urandom_range(0, 1) == 1;
		t.flush           = $urandom_range(0, 99) < flush_pct;
		t.buffer_mode     = $urandom_range(0, 99) < buffer_pct;
		t.buffer_address  = pick_addr();
		t.buffer_word     = $urandom();
		return t;
	endfunction

	// Offer one word after an optional gap and hold it until accepted
	task automatic send_tick(input ifr_pkg::item_t t, input int gap);
		@(negedge clk);
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		predict_valid   <= t.predict_valid;
		predict_address <= t.predict_address;
		mem_accept      <= t.mem_accept;
		resp_valid      <= t.resp_valid;
		resp_address    <= t.resp_address;
		resp_word       <= t.resp_word;
		resp_fault      <= t.resp_fault;
		resp_exec_ok    <= t.resp_exec_ok;
		flush           <= t.flush;
		buffer_mode     <= t.buffer_mode;
		buffer_address  <= t.buffer_address;
		buffer_word     <= t.buffer_word;
		item_valid      <= 1'b1;
		ticks_sent++;
		if (t.flush)
			flush_ticks++;
		if (t.buffer_mode)
			buffer_ticks++;
		forever begin
			@(posedge clk);
			if (!item_stall)
				break;
		end
	endtask

	// Drop valid and hold until every result word is back
	task automatic drain_pause();
		@(negedge clk);
		item_valid <= 1'b0;
		wait (expected_left == 0);
	endtask

	// Receiver: random stalls, quiet stretches, and a long hold-off on request
	initial begin : result_side
		int burst;
		int served;
		int cyc;
		int r;

		burst  = 0;
		served = 0;
		cyc    = 0;
		result_stall = 1'b0;
		forever begin
			@(negedge clk);
			cyc++;
			if (hold_requests != served) begin
				served = hold_requests;
				result_stall <= 1'b1;
				repeat (HOLD_OFF_LEN) @(negedge clk);
			end
			if (burst > 0) begin
				burst--;
				result_stall <= 1'b1;
			end else if (cyc % 512 >= 448) begin
				result_stall <= 1'b0;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 70) begin
					result_stall <= 1'b0;
				end else if (r < 95) begin
					burst = $urandom_range(0, 3);
					result_stall <= 1'b1;
				end else begin
					burst = $urandom_range(10, 40);
					result_stall <= 1'b1;
				end
			end
		end
	end

	// End the run if neither channel moves for too long
	initial begin : watchdog
		int idle_cycles;

		idle_cycles = 0;
		wait (arst_n === 1'b1);
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((item_valid && !item_stall) || (result_valid && !result_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("instruction_fetch_request_fsm_core test failed");
		$finish;
	end

	// Stimulus and verdict
	initial begin : stimulus
		int flush_pct;
		int buffer_pct;
		int gap;

		arst_n          = 1'b0;
		item_valid      = 1'b0;
		predict_valid   = 1'b0;
		predict_address = '0;
		mem_accept      = 1'b0;
		resp_valid      = 1'b0;
		resp_address    = '0;
		resp_word       = '0;
		resp_fault      = 1'b0;
		resp_exec_ok    = 1'b0;
		flush           = 1'b0;
		buffer_mode     = 1'b0;
		buffer_address  = '0;
		buffer_word     = '0;
		flush_pct       = 2;
		buffer_pct      = 3;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;

		// idle: nothing, then program-buffer injection at both extremes
		send_tick(make_tick(0, '0, 0, 0, '0, '0, 0, 0, 0, 0, '0, '0), 0);
		send_tick(make_tick(0, '0, 0, 0, '0, '0, 0, 0, 0, 1, '1, '1), 0);
		send_tick(make_tick(0, '0, 0, 0, '0, '0, 0, 0, 0, 1, '0, '0), 1);
		// buffer mode takes priority over a predicted address
		send_tick(make_tick(1, 32'h1234_5678, 1, 1, '1, '1, 1, 1, 0, 1,
			32'h0000_0800, 32'hDEAD_BEEF), 0);
		// start a request, retarget it while not accepted, then hold
		send_tick(make_tick(1, '1, 0, 0, '0, '0, 0, 0, 0, 0, '0, '0), 0);
		send_tick(make_tick(1, '0, 0, 1, '1, '1, 1, 1, 0, 0, '0, '0), 0);
		send_tick(make_tick(0, '1, 0, 0, '0, '0, 0, 0, 0, 0, '0, '0), 2);
		// accept with a next address pending
		send_tick(make_tick(1, 32'h0000_1000, 1, 0, '0, '0, 0, 0, 0, 0, '0, '0), 0);
		send_tick(make_tick(0, '0, 0, 0, '1, '1, 1, 1, 0, 0, '0, '0), 0);
		// response while pending and not accepted: back to accept wait
		send_tick(make_tick(1, 32'h0000_1004, 0, 1, '1, '1, 1, 1, 0, 0, '0, '0), 0);
		send_tick(make_tick(0, '0, 1, 0, '0, '0, 0, 0, 0, 0, '0, '0), 0);
		// response with nothing pending but a new prediction
		send_tick(make_tick(1, 32'h8000_0000, 0, 1, '0, '0, 0, 1, 0, 0, '0, '0), 0);
		send_tick(make_tick(1, 32'h8000_0004, 1, 0, '0, '0, 0, 0, 0, 0, '0, '0), 0);
		// response and accept together keep the wait phase
		send_tick(make_tick(1, 32'h8000_0008, 1, 1, 32'h8000_0000, 32'h0000_0013, 0, 1,
			0, 0, '0, '0), 0);
		send_tick(make_tick(0, '0, 1, 1, 32'h8000_0004, 32'hFFFF_0000, 1, 0,
			0, 0, '0, '0), 0);
		// response with nothing further to fetch parks the address
		send_tick(make_tick(0, '0, 0, 1, 32'h8000_0008, 32'h0000_FFFF, 0, 0,
			0, 0, '0, '0), 0);
		// flush in each phase
		send_tick(make_tick(1, 32'h0000_2000, 0, 0, '0, '0, 0, 0, 1, 0, '0, '0), 0);
		send_tick(make_tick(1, 32'h0000_2004, 1, 0, '0, '0, 0, 0, 1, 0, '0, '0), 0);
		send_tick(make_tick(1, 32'h0000_2008, 0, 1, '1, '1, 1, 1, 1, 0, '0, '0), 0);
		send_tick(make_tick(0, '0, 1, 1, '1, '1, 1, 1, 0, 1, '1, '1), 0);
		send_tick(make_tick(0, '0, 0, 1, '0, '0, 0, 0, 0, 1, '1, '1), 0);
		send_tick(make_tick(0, '0, 0, 0, '0, '0, 0, 0, 1, 1, '1, '1), 0);
		drain_pause();

		// random ticks in blocks with varying flush and buffer-mode density
		for (int i = 0; i < RANDOM_TICKS; i++) begin
			if (i % 125 == 0) begin
				case ($urandom_range(0, 3))
					0: begin flush_pct = 2;  buffer_pct = 3;  end
					1: begin flush_pct = 8;  buffer_pct = 10; end
					2: begin flush_pct = 30; buffer_pct = 5;  end
					default: begin flush_pct = 5; buffer_pct = 50; end
				endcase
			end
			if (i == HOLD_OFF_START)
				hold_requests++;
			if (i == DRAIN_AT)
				drain_pause();
			if (i >= HOLD_OFF_START && i < HOLD_OFF_START + HOLD_OFF_BURST)
				gap = 0;
			else
				gap = pick_gap(i);
			send_tick(random_tick(flush_pct, buffer_pct), gap);
		end
		@(negedge clk);
		item_valid <= 1'b0;

		// drain, then keep the clock running before the verdict to catch stray result words
		wait (expected_left == 0);
		repeat (4) @(posedge clk);
		@(negedge clk);

		$display("drove %0d ticks (%0d flush, %0d program buffer), checked %0d results",
			ticks_sent, flush_ticks, buffer_ticks, words_checked);
		$display("run included a long output hold-off with input backpressure and drain pauses");
		if (fail_count == 0)
			$display("instruction_fetch_request_fsm_core test passed");
		else
			$display("instruction_fetch_request_fsm_core test failed");
		$finish;
	end

endmodule
